// ===== src/first_fit_contiguous_block_allocator_unit_defines.svh =====
// Assertion macros for the first-fit block allocator.
// Depends on clk and rst being visible where a macro is used.
`ifndef FIRST_FIT_CONTIGUOUS_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_CONTIGUOUS_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define FFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define FFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define FFA_ASSERT_NOW(lbl, ante, cons, msg)
`define FFA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/ffa_pkg.sv =====
// Shared types and constants for the first-fit block allocator.
// No dependencies.
`timescale 1ns / 1ps

package ffa_pkg;

  // request op codes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_MARK  = 2'd2;

  // field widths
  localparam int OP_W    = 2;
  localparam int BLK_W   = 7;
  localparam int IN_W    = 16;
  localparam int OUT_W   = 8;

  // a run may only begin below this block
  localparam int START_LIMIT = 128;

  typedef struct packed {
    logic             status;
    logic [BLK_W-1:0] run_start;
  } result_t;

endpackage

// ===== src/ffa_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module ffa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/ffa_ctrl.sv =====
// Request sequencer: clearing pass, bitmap scan, range write and result register.
// Depends on ffa_pkg; drives the bitmap RAM ports.
`timescale 1ns / 1ps

module ffa_ctrl #(
  parameter int NUM_DISK_BLOCKS = 128
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [ffa_pkg::OP_W-1:0]             in_op,
  input  logic [ffa_pkg::BLK_W-1:0]            in_first,
  input  logic [ffa_pkg::BLK_W-1:0]            in_count,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output ffa_pkg::result_t                     out_word,
  output logic                                 mem_we,
  output logic [$clog2(NUM_DISK_BLOCKS)-1:0]   mem_waddr,
  output logic                                 mem_wdata,
  output logic                                 mem_re,
  output logic [$clog2(NUM_DISK_BLOCKS)-1:0]   mem_raddr,
  input  logic                                 mem_rdata
);
  import ffa_pkg::*;

  localparam int AW = $clog2(NUM_DISK_BLOCKS);
  localparam int BW = (AW + 1 > 8) ? AW + 1 : 8;
  localparam logic [BW-1:0] NUM_BW  = BW'(NUM_DISK_BLOCKS);
  localparam logic [BW-1:0] LAST_BW = BW'(NUM_DISK_BLOCKS - 1);
  localparam logic [BW-1:0] LIM_BW  = BW'(START_LIMIT);
  localparam logic [AW-1:0] LAST_AW = AW'(NUM_DISK_BLOCKS - 1);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SCAN, S_WRITE, S_DONE} state_t;

  state_t           state;
  logic [AW-1:0]    clr_cnt;
  logic [BLK_W-1:0] first_q;
  logic [BLK_W-1:0] count_q;
  logic [BLK_W-1:0] k;
  logic             fill_val;
  logic [BW-1:0]    iss;
  logic             rd_vld;
  logic [BW-1:0]    rd_blk;
  logic [BLK_W-1:0] run;
  logic [BLK_W-1:0] begin_q;
  result_t          res;

  logic [BW-1:0]    wr_blk;
  logic             hit_free;
  logic             start_ok;
  logic             run_done;
  logic             scan_fail;
  logic [BLK_W-1:0] start_now;

  assign in_ready = (state == S_IDLE);

  // block addressed by the range walk
  assign wr_blk = BW'(first_q) + BW'(k);

  // scan decisions for the word coming back from the RAM
  assign hit_free  = rd_vld && !mem_rdata;
  assign start_ok  = !((run == '0) && (rd_blk >= LIM_BW));
  assign run_done  = hit_free && start_ok && ((run + BLK_W'(1)) == count_q);
  assign scan_fail = rd_vld && ((hit_free && !start_ok) ||
                                (!run_done && (rd_blk == LAST_BW)));
  assign start_now = (run == '0) ? rd_blk[BLK_W-1:0] : begin_q;

  // RAM port drive
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = iss[AW-1:0];
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = (clr_cnt == '0);
      end
      S_WRITE: begin
        mem_we    = (k != count_q) && (wr_blk < NUM_BW);
        mem_waddr = wr_blk[AW-1:0];
        mem_wdata = (wr_blk == '0) ? 1'b1 : fill_val;
      end
      S_SCAN: begin
        mem_re = (iss < NUM_BW) && !run_done && !scan_fail;
      end
      default: begin
      end
    endcase
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // a word leaving while the next one is loaded keeps out_valid high
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == LAST_AW) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            first_q <= in_first;
            count_q <= in_count;
            k       <= '0;
            res     <= '0;
            case (in_op)
              OP_ALLOC: begin
                iss    <= BW'(1);
                run    <= '0;
                rd_vld <= 1'b0;
                state  <= (in_count == '0) ? S_DONE : S_SCAN;
              end
              OP_FREE: begin
                fill_val <= 1'b0;
                state    <= S_WRITE;
              end
              OP_MARK: begin
                fill_val <= 1'b1;
                state    <= S_WRITE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (mem_re) begin
            iss <= iss + BW'(1);
          end
          // no read is issued once the scan decides, so rd_vld drops here
          rd_vld <= mem_re;
          rd_blk <= iss;
          if (run_done) begin
            first_q       <= start_now;
            k             <= '0;
            fill_val      <= 1'b1;
            res.run_start <= start_now;
            state         <= S_WRITE;
          end else if (scan_fail) begin
            res.status <= 1'b1;
            state      <= S_DONE;
          end else if (rd_vld) begin
            if (hit_free) begin
              if (run == '0) begin
                begin_q <= rd_blk[BLK_W-1:0];
              end
              run <= run + BLK_W'(1);
            end else begin
              run <= '0;
            end
          end
        end
        S_WRITE: begin
          if (k == count_q) begin
            state <= S_DONE;
          end else begin
            k <= k + BLK_W'(1);
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_word  <= res;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/first_fit_contiguous_block_allocator_unit.sv =====
// First-fit contiguous block allocator over a used-block bitmap in RAM.
// Allocate: a bit-serial scan through the single RAM read port, then the range write through
// its write port. Free/mark: the range write only; zero-length alloc or unused op: no scan
// or write, the result only. m_tvalid rises as s_tready returns; one word in flight. Reset
// (synchronous, rst high) starts a clearing pass of the bitmap; s_tready stays low until it
// ends.
`timescale 1ns / 1ps
`include "first_fit_contiguous_block_allocator_unit_defines.svh"

module first_fit_contiguous_block_allocator_unit #(
  parameter int NUM_DISK_BLOCKS = 128
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [ffa_pkg::IN_W-1:0]   s_tdata,   // op[1:0], first_block[8:2], block_count[15:9]
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [ffa_pkg::OUT_W-1:0]  m_tdata    // run_start[6:0], status[7]
);
  import ffa_pkg::*;

  localparam int AW = $clog2(NUM_DISK_BLOCKS);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic          mem_rdata;
  result_t       out_word;

  // bitmap storage
  ffa_ram #(
    .WIDTH(1),
    .DEPTH(NUM_DISK_BLOCKS)
  ) u_map (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // request sequencer
  ffa_ctrl #(
    .NUM_DISK_BLOCKS(NUM_DISK_BLOCKS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_op    (s_tdata[1:0]),
    .in_first (s_tdata[8:2]),
    .in_count (s_tdata[15:9]),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_word (out_word),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re   (mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  assign m_tdata = {out_word.status, out_word.run_start};

  // checks
  `FFA_ASSERT_NEXT(a_one_word, s_tvalid && s_tready, !s_tready, "second word taken while busy")
  `FFA_ASSERT_NOW(a_rw_excl, mem_we, !mem_re, "bitmap read and write in one cycle")
  `FFA_ASSERT_NOW(a_blk0_kept, mem_we && (mem_waddr == '0), mem_wdata, "block 0 cleared")
  `FFA_ASSERT_NOW(a_fail_zero, m_tvalid && m_tdata[7], m_tdata[6:0] == '0, "failed alloc with start")

endmodule
